### rtl/core/maf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// maf_pkg
// Shared constants, types and helpers for the moving-average filter.
// ----------------------------------------------------------------------------
package maf_pkg;

	localparam int MAX_WINDOW = 256;
	localparam int SAMPLE_W   = 16;
	localparam int LEN_W      = 9;
	localparam int PTR_W      = $clog2(MAX_WINDOW);
	localparam int CNT_W      = $clog2(MAX_WINDOW + 1);
	localparam int SUM_W      = SAMPLE_W + PTR_W;

	// divider retires this many quotient bits per cycle
	localparam int DIV_BITS   = 2;
	localparam int DIV_ITERS  = (SUM_W + DIV_BITS - 1) / DIV_BITS;
	localparam int DIV_STEP_W = (DIV_ITERS > 1) ? $clog2(DIV_ITERS) : 1;

	localparam int APB_DATA_W = 32;
	localparam int ADDR_W     = 3;
	localparam int REG_IDX_W  = ADDR_W - 2;
	localparam logic [REG_IDX_W-1:0] REG_WINDOW_LENGTH = '0;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic signed [SUM_W-1:0]    sum_t;
	typedef logic [CNT_W-1:0]           count_t;
	typedef logic [PTR_W-1:0]           ptr_t;

	typedef enum logic [2:0] {
		C_IDLE,
		C_CHECK,
		C_EVICT,
		C_INSERT,
		C_LAUNCH
	} ctrl_state_t;

	typedef struct packed {
		logic    we;
		ptr_t    waddr;
		sample_t wdata;
		logic    re;
		ptr_t    raddr;
	} ram_req_t;

	typedef struct packed {
		logic   start;
		sum_t   sum;
		count_t count;
	} div_req_t;

	function automatic count_t eff_len(logic [LEN_W-1:0] raw);
		count_t len;
		if (raw == '0) begin
			len = count_t'(1);
		end else if (int'(raw) > MAX_WINDOW) begin
			len = count_t'(MAX_WINDOW);
		end else begin
			len = count_t'(raw);
		end
		return len;
	endfunction

	function automatic sum_t sext_sample(sample_t s);
		return {{(SUM_W - SAMPLE_W){s[SAMPLE_W-1]}}, s};
	endfunction

endpackage

### rtl/core/maf_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// maf_if
// Valid/ready channels for samples in and averages out.
// ----------------------------------------------------------------------------
interface maf_in_if;
	import maf_pkg::*;

	logic    valid;
	logic    ready;
	sample_t sample;
	logic    restart;

	modport source (output valid, output sample, output restart, input ready);
	modport sink   (input valid, input sample, input restart, output ready);
endinterface

interface maf_out_if;
	import maf_pkg::*;

	logic    valid;
	logic    ready;
	sample_t average;

	modport source (output valid, output average, input ready);
	modport sink   (input valid, input average, output ready);
endinterface

### rtl/core/maf_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// maf_ram
// Generic single-clock RAM, one write and one read port, registered read.
// ----------------------------------------------------------------------------
module maf_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### rtl/core/maf_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// maf_ctrl
// Window sequencer: evicts old samples from the store, inserts the new one
// and keeps the running sum and count, then hands them to the divider.
// ----------------------------------------------------------------------------
module maf_ctrl (
	input  logic                     clk,
	input  logic                     arst_n,
	maf_in_if.sink                   din,
	input  logic [maf_pkg::LEN_W-1:0] window_length,
	output maf_pkg::ram_req_t        ram_req,
	input  maf_pkg::sample_t         ram_rdata,
	output maf_pkg::div_req_t        div_req,
	input  logic                     div_ready
);
	import maf_pkg::*;

	ctrl_state_t state_q, state_d;
	sum_t        sum_q, sum_d;
	count_t      cnt_q, cnt_d;
	ptr_t        ptr_q, ptr_d;
	sample_t     sample_q;
	count_t      len_q;
	logic        take;

	assign take = din.valid && din.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			sum_q   <= '0;
			cnt_q   <= '0;
			ptr_q   <= '0;
		end else begin
			state_q <= state_d;
			sum_q   <= sum_d;
			cnt_q   <= cnt_d;
			ptr_q   <= ptr_d;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			sample_q <= din.sample;
			len_q    <= eff_len(window_length);
		end
	end

	always_comb begin
		state_d       = state_q;
		sum_d         = sum_q;
		cnt_d         = cnt_q;
		ptr_d         = ptr_q;
		din.ready     = 1'b0;
		ram_req       = '0;
		div_req.start = 1'b0;
		div_req.sum   = sum_q;
		div_req.count = cnt_q;

		case (state_q)
			C_IDLE: begin
				din.ready = 1'b1;
				if (din.valid) begin
					// restart empties the window before the sample goes in
					if (din.restart) begin
						sum_d = '0;
						cnt_d = '0;
						ptr_d = '0;
					end
					state_d = C_CHECK;
				end
			end
			C_CHECK: begin
				if (cnt_q >= len_q) begin
					ram_req.re    = 1'b1;
					ram_req.raddr = ptr_q;
					state_d       = C_EVICT;
				end else begin
					state_d = C_INSERT;
				end
			end
			C_EVICT: begin
				sum_d   = sum_q - sext_sample(ram_rdata);
				ptr_d   = ptr_q + ptr_t'(1);
				cnt_d   = cnt_q - count_t'(1);
				state_d = C_CHECK;
			end
			C_INSERT: begin
				ram_req.we    = 1'b1;
				ram_req.waddr = ptr_q + cnt_q[PTR_W-1:0];
				ram_req.wdata = sample_q;
				sum_d         = sum_q + sext_sample(sample_q);
				cnt_d         = cnt_q + count_t'(1);
				state_d       = C_LAUNCH;
			end
			C_LAUNCH: begin
				if (div_ready) begin
					div_req.start = 1'b1;
					state_d       = C_IDLE;
				end
			end
			default: begin
				state_d = C_IDLE;
			end
		endcase
	end

endmodule

### rtl/core/maf_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// maf_div
// Iterative signed divide of the window sum by the held count, truncating
// toward zero, with the result held in the output register.
// ----------------------------------------------------------------------------
module maf_div (
	input  logic              clk,
	input  logic              arst_n,
	input  maf_pkg::div_req_t req,
	output logic              ready,
	maf_out_if.source         dout
);
	import maf_pkg::*;

	logic                  busy_q;
	logic                  res_valid_q;
	logic                  neg_q;
	logic [SUM_W-1:0]      quo_q;
	logic [CNT_W:0]        rem_q;
	count_t                den_q;
	logic [DIV_STEP_W-1:0] step_q;
	sample_t               res_q;

	logic [SUM_W-1:0] quo_n;
	logic [CNT_W:0]   rem_n;
	logic [SUM_W-1:0] mag;
	logic [SUM_W-1:0] signed_q;
	logic             last;
	logic             take;
	logic             finish;

	assign ready  = !busy_q;
	assign take   = res_valid_q && dout.ready;
	assign last   = (step_q == DIV_STEP_W'(DIV_ITERS - 1));
	assign finish = busy_q && last && (!res_valid_q || take);

	assign mag = req.sum[SUM_W-1] ? SUM_W'(-req.sum) : SUM_W'(req.sum);

	// restoring division, DIV_BITS quotient bits per cycle
	always_comb begin
		logic [CNT_W:0]   r;
		logic [SUM_W-1:0] q;
		r = rem_q;
		q = quo_q;
		for (int i = 0; i < DIV_BITS; i++) begin
			r = {r[CNT_W-1:0], q[SUM_W-1]};
			q = {q[SUM_W-2:0], 1'b0};
			if (r >= {1'b0, den_q}) begin
				r    = r - {1'b0, den_q};
				q[0] = 1'b1;
			end
		end
		rem_n = r;
		quo_n = q;
	end

	assign signed_q = neg_q ? (~quo_n + SUM_W'(1)) : quo_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (req.start && !busy_q) begin
				busy_q <= 1'b1;
			end else if (finish) begin
				busy_q <= 1'b0;
			end
			if (finish) begin
				res_valid_q <= 1'b1;
			end else if (take) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start && !busy_q) begin
			quo_q  <= mag;
			rem_q  <= '0;
			den_q  <= req.count;
			neg_q  <= req.sum[SUM_W-1];
			step_q <= '0;
		end else if (busy_q && !last) begin
			quo_q  <= quo_n;
			rem_q  <= rem_n;
			step_q <= step_q + DIV_STEP_W'(1);
		end
		if (finish) begin
			res_q <= signed_q[SAMPLE_W-1:0];
		end
	end

	assign dout.valid   = res_valid_q;
	assign dout.average = res_q;

endmodule

### rtl/core/moving_average_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// moving_average_filter
// Boxcar moving average over signed samples, window set by register.
// ----------------------------------------------------------------------------
// Samples arrive on din (sample, restart) and one average leaves on dout for
// every sample, in order. restart empties the window before its sample, so
// the first average of a record is that sample itself.
// The window length register (address 0) sets how many recent samples are
// averaged; 0 acts as 1 and values above 256 as 256. Write it only while the
// filter is idle.
// After accept a request passes the check, insert and launch states, with an
// extra check and evict state for each of the E samples evicted (1 once the
// window is full, 0 while filling, more after the length is lowered), then
// goes to the divider, which retires two quotient bits per cycle. A new
// request can be taken while the divider works on the previous one, so
// back-to-back throughput is set by the divider. Each eviction reads one entry.
// The result sits in an output register: the next request is taken and
// worked on while dout stalls, and the divider holds until it drains.
// Reset empties the window and sets the length to 1; the store is not cleared.
// ----------------------------------------------------------------------------
module moving_average_filter (
	input  logic                               clk,
	input  logic                               arst_n,
	maf_in_if.sink                             din,
	maf_out_if.source                          dout,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [maf_pkg::ADDR_W-1:0]         paddr,
	input  logic [maf_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [maf_pkg::APB_DATA_W-1:0]     prdata,
	output logic                               pready
);
	import maf_pkg::*;

	logic [LEN_W-1:0] wlen_q;
	logic             reg_hit;
	ram_req_t         ram_req;
	sample_t          ram_rdata;
	div_req_t         div_req;
	logic             div_ready;

	assign pready  = 1'b1;
	assign reg_hit = (paddr[ADDR_W-1:2] == REG_WINDOW_LENGTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wlen_q <= LEN_W'(1);
		end else if (psel && penable && pwrite && reg_hit) begin
			wlen_q <= pwdata[LEN_W-1:0];
		end
	end

	assign prdata = reg_hit ? {{(APB_DATA_W - LEN_W){1'b0}}, wlen_q} : '0;

	maf_ram #(
		.WIDTH (SAMPLE_W),
		.DEPTH (MAX_WINDOW)
	) u_store (
		.clk   (clk),
		.we    (ram_req.we),
		.waddr (ram_req.waddr),
		.wdata (ram_req.wdata),
		.re    (ram_req.re),
		.raddr (ram_req.raddr),
		.rdata (ram_rdata)
	);

	maf_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.din           (din),
		.window_length (wlen_q),
		.ram_req       (ram_req),
		.ram_rdata     (ram_rdata),
		.div_req       (div_req),
		.div_ready     (div_ready)
	);

	maf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.ready  (div_ready),
		.dout   (dout)
	);

endmodule

### rtl/core/maf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// maf_checker
// Port-level checks on the filter's request and result channels.
// ----------------------------------------------------------------------------
module maf_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_ready,
	input logic             out_valid,
	input logic             out_ready,
	input maf_pkg::sample_t average
);
	import maf_pkg::*;

	logic [2:0] pending_q;
	logic       in_take;
	logic       out_take;

	assign in_take  = in_valid && in_ready;
	assign out_take = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else begin
			pending_q <= pending_q + 3'(in_take) - 3'(out_take);
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(average))
		else $error("result dropped or changed while stalled");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_take |=> !in_ready)
		else $error("request taken while previous one in the window logic");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pending_q != 3'd0)
		else $error("result with no request outstanding");

	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= 3'd3)
		else $error("more requests in flight than the filter can hold");

endmodule

bind moving_average_filter maf_checker u_maf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (din.valid),
	.in_ready  (din.ready),
	.out_valid (dout.valid),
	.out_ready (dout.ready),
	.average   (dout.average)
);
